// ===== src/sfls_pkg.sv =====
// Shared types, constants and the sequencer control store of the stereo FIR level scaler.
`timescale 1ns / 1ps
`default_nettype none
package sfls_pkg;

  // Word field widths
  localparam int SAMPLE_W = 24;
  localparam int COEF_W   = 32;
  localparam int LEVEL_W  = 16;
  localparam int INDEX_W  = 6;
  localparam int ACTION_W = 2;
  localparam int PROD_W   = SAMPLE_W + COEF_W;
  localparam int SPROD_W  = SAMPLE_W + LEVEL_W + 1;

  // Fixed-point shifts
  localparam int FIR_SHIFT   = 31;
  localparam int LEVEL_SHIFT = 15;

  // Action codes of an input word
  localparam logic [ACTION_W-1:0] ACT_PROCESS = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_COEF    = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR   = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_FILTER_ENABLE = 2'd0;
  localparam logic [1:0] REG_LEVEL_LEFT    = 2'd1;
  localparam logic [1:0] REG_LEVEL_RIGHT   = 2'd2;

  // Sequencer step addresses
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_FETCH  = 4'd0;
  localparam logic [STEP_W-1:0] STEP_COEF   = 4'd1;
  localparam logic [STEP_W-1:0] STEP_CLEAR  = 4'd2;
  localparam logic [STEP_W-1:0] STEP_PROC_F = 4'd3;
  localparam logic [STEP_W-1:0] STEP_LOOP   = 4'd4;
  localparam logic [STEP_W-1:0] STEP_DRAIN1 = 4'd5;
  localparam logic [STEP_W-1:0] STEP_DRAIN2 = 4'd6;
  localparam logic [STEP_W-1:0] STEP_X_FIR  = 4'd7;
  localparam logic [STEP_W-1:0] STEP_SCALE  = 4'd8;
  localparam logic [STEP_W-1:0] STEP_OUT    = 4'd9;
  localparam logic [STEP_W-1:0] STEP_PROC_P = 4'd10;

  // Sequencing kinds of a control word
  localparam logic [2:0] SEQ_NEXT     = 3'd0;
  localparam logic [2:0] SEQ_GOTO     = 3'd1;
  localparam logic [2:0] SEQ_LOOP     = 3'd2;
  localparam logic [2:0] SEQ_DISPATCH = 3'd3;
  localparam logic [2:0] SEQ_WAIT_OUT = 3'd4;

  // One control word
  typedef struct packed {
    logic [2:0]        seq;
    logic [STEP_W-1:0] target;
    logic              hist_wr;
    logic              hist_clr;
    logic              coef_wr;
    logic              tap_init;
    logic              tap_rd;
    logic              x_fir;
    logic              x_in;
    logic              scale_en;
    logic              out_load;
  } ucode_t;

  // Datapath controls for one channel
  typedef struct packed {
    logic acc_clr;
    logic prod_en;
    logic acc_en;
    logic x_fir;
    logic x_in;
    logic scale_en;
    logic out_load;
  } mac_ctrl_t;

  // Control store
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] addr);
    ucode_t w;
    w = '0;
    w.seq = SEQ_GOTO;
    w.target = STEP_FETCH;
    case (addr)
      STEP_FETCH: begin
        w.seq = SEQ_DISPATCH;
      end
      STEP_COEF: begin
        w.coef_wr = 1'b1;
      end
      STEP_CLEAR: begin
        w.hist_clr = 1'b1;
      end
      STEP_PROC_F: begin
        w.seq      = SEQ_NEXT;
        w.hist_wr  = 1'b1;
        w.tap_init = 1'b1;
      end
      STEP_LOOP: begin
        w.seq    = SEQ_LOOP;
        w.target = STEP_LOOP;
        w.tap_rd = 1'b1;
      end
      STEP_DRAIN1: begin
        w.seq = SEQ_NEXT;
      end
      STEP_DRAIN2: begin
        w.seq = SEQ_NEXT;
      end
      STEP_X_FIR: begin
        w.seq   = SEQ_NEXT;
        w.x_fir = 1'b1;
      end
      STEP_SCALE: begin
        w.seq      = SEQ_NEXT;
        w.scale_en = 1'b1;
      end
      STEP_OUT: begin
        w.seq      = SEQ_WAIT_OUT;
        w.out_load = 1'b1;
      end
      STEP_PROC_P: begin
        w.target = STEP_SCALE;
        w.x_in   = 1'b1;
      end
      default: begin
        w.seq = SEQ_GOTO;
      end
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// ===== src/sfls_ram.sv =====
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
`default_nettype none
module sfls_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 32
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/sfls_mac.sv =====
// One channel's multiply-accumulate, tap sum truncation and level scaling datapath.
`timescale 1ns / 1ps
`default_nettype none
module sfls_mac #(
  parameter int TAPS = 32
) (
  input  wire logic                              clk,
  input  wire sfls_pkg::mac_ctrl_t               ctrl,
  input  wire logic [sfls_pkg::SAMPLE_W-1:0]     hist_data,
  input  wire logic                              hist_vld,
  input  wire logic [sfls_pkg::COEF_W-1:0]       coef_data,
  input  wire logic                              coef_vld,
  input  wire logic [sfls_pkg::SAMPLE_W-1:0]     sample,
  input  wire logic [sfls_pkg::LEVEL_W-1:0]      level,
  output logic      [sfls_pkg::SAMPLE_W-1:0]     result
);
  import sfls_pkg::*;

  localparam int ACC_W = PROD_W + $clog2(TAPS + 1);

  logic signed [SAMPLE_W-1:0] h;
  logic signed [COEF_W-1:0]   c;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    acc;
  logic signed [SAMPLE_W-1:0] x;
  logic signed [LEVEL_W:0]    lvl_s;
  logic signed [SPROD_W-1:0]  sprod;

  // Unwritten entries read as zero
  assign h     = hist_vld ? hist_data : '0;
  assign c     = coef_vld ? coef_data : '0;
  assign lvl_s = {1'b0, level};

  // Tap product, then accumulate at full precision
  always_ff @(posedge clk) begin
    if (ctrl.prod_en) begin
      prod <= h * c;
    end
    if (ctrl.acc_clr) begin
      acc <= '0;
    end else if (ctrl.acc_en) begin
      acc <= acc + {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};
    end
  end

  // Select the value to scale: filtered sum or raw sample
  always_ff @(posedge clk) begin
    if (ctrl.x_fir) begin
      x <= acc[FIR_SHIFT + SAMPLE_W - 1:FIR_SHIFT];
    end else if (ctrl.x_in) begin
      x <= sample;
    end
  end

  // Apply level and hold the result word
  always_ff @(posedge clk) begin
    if (ctrl.scale_en) begin
      sprod <= x * lvl_s;
    end
    if (ctrl.out_load) begin
      result <= sprod[LEVEL_SHIFT + SAMPLE_W - 1:LEVEL_SHIFT];
    end
  end

endmodule
`default_nettype wire

// ===== src/stereo_fir_level_scaler_unit.sv =====
// Top level of the stereo FIR level scaler: sequencer, coefficient and history stores.
//
// Input channel (in_valid/in_ready) takes one word: an action code with a stereo
// sample pair, or a coefficient slot and value. A process word yields one result
// word on the output channel (out_valid/out_ready); coefficient, clear and
// unused-action words yield none. The APB port sets filter_enable and the levels.
//
// Sequence from accept to the next accept: filter on, the one multiply-accumulate
// per channel steps through the history and coefficient memories one tap per
// cycle, then the sum is drained, shifted into a sample word, scaled and loaded;
// filter off, the raw sample is scaled and loaded; coefficient write and clear
// do their store action and return to fetch; an unused action stays in fetch.
// The result waits in an output register; while the receiver stalls the next
// word is still taken and worked on, and the sequencer holds in its final
// step until the register is free.
// Reset clears the control registers and the valid bits of both stores, so history and
// coefficients read as zero at once; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module stereo_fir_level_scaler_unit #(
  parameter int TAPS = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // input words
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [sfls_pkg::ACTION_W-1:0]     action,
  input  wire logic [sfls_pkg::SAMPLE_W-1:0]     left_in,
  input  wire logic [sfls_pkg::SAMPLE_W-1:0]     right_in,
  input  wire logic [sfls_pkg::INDEX_W-1:0]      coef_index,
  input  wire logic [sfls_pkg::COEF_W-1:0]       coef_value,
  // result words
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic      [sfls_pkg::SAMPLE_W-1:0]     left_out,
  output logic      [sfls_pkg::SAMPLE_W-1:0]     right_out,
  // configuration
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [3:0]                        paddr,
  input  wire logic [31:0]                       pwdata,
  output logic      [31:0]                       prdata,
  output logic                                   pready
);
  import sfls_pkg::*;

  localparam int TW = TAPS > 1 ? $clog2(TAPS) : 1;
  localparam logic [TW-1:0] LAST_TAP = TW'(TAPS - 1);
  localparam logic [8:0]    TAPS_9   = 9'(TAPS);
  localparam logic [8:0]    SLOTS_9  = 9'(2 * TAPS);

  // configuration registers
  logic                filter_enable;
  logic [LEVEL_W-1:0]  level_left;
  logic [LEVEL_W-1:0]  level_right;
  logic                cfg_we;

  // sequencer
  logic [STEP_W-1:0]   step;
  logic [STEP_W-1:0]   step_next;
  ucode_t              uc;
  logic                accept;
  logic                out_free;

  // latched input word
  logic [SAMPLE_W-1:0] left_q;
  logic [SAMPLE_W-1:0] right_q;
  logic [INDEX_W-1:0]  index_q;
  logic [COEF_W-1:0]   value_q;

  // stores and tap walk
  logic [TW-1:0]       wp;
  logic [TW-1:0]       wp_next;
  logic [TW-1:0]       hist_ra;
  logic [TW-1:0]       tap_cnt;
  logic                tap_last;
  logic [TAPS-1:0]     hist_vld;
  logic [TAPS-1:0]     coef_vld_l;
  logic [TAPS-1:0]     coef_vld_r;
  logic                hist_vld_q;
  logic                coef_vld_l_q;
  logic                coef_vld_r_q;
  logic                rd_v1;
  logic                rd_v2;
  logic [8:0]          idx9;
  logic [8:0]          idx_r9;
  logic                coef_we_l;
  logic                coef_we_r;
  logic [TW-1:0]       coef_wa_l;
  logic [TW-1:0]       coef_wa_r;
  logic [SAMPLE_W-1:0] hist_rd_l;
  logic [SAMPLE_W-1:0] hist_rd_r;
  logic [COEF_W-1:0]   coef_rd_l;
  logic [COEF_W-1:0]   coef_rd_r;
  mac_ctrl_t           mctrl;

  // APB register bank
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_enable <= 1'b0;
      level_left    <= '0;
      level_right   <= '0;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        REG_FILTER_ENABLE: filter_enable <= pwdata[0];
        REG_LEVEL_LEFT:    level_left    <= pwdata[LEVEL_W-1:0];
        REG_LEVEL_RIGHT:   level_right   <= pwdata[LEVEL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_FILTER_ENABLE: prdata = {31'd0, filter_enable};
      REG_LEVEL_LEFT:    prdata = {16'd0, level_left};
      REG_LEVEL_RIGHT:   prdata = {16'd0, level_right};
      default:           prdata = '0;
    endcase
  end

  // Fetch control word and pick the next step
  assign uc       = ucode_rom(step);
  assign in_ready = (uc.seq == SEQ_DISPATCH);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign tap_last = (tap_cnt == LAST_TAP);

  always_comb begin
    step_next = step;
    unique case (uc.seq)
      SEQ_NEXT: step_next = step + 1'b1;
      SEQ_GOTO: step_next = uc.target;
      SEQ_LOOP: step_next = tap_last ? step + 1'b1 : uc.target;
      SEQ_DISPATCH: begin
        if (accept) begin
          priority if (action == ACT_PROCESS) begin
            step_next = filter_enable ? STEP_PROC_F : STEP_PROC_P;
          end else if (action == ACT_COEF) begin
            step_next = STEP_COEF;
          end else if (action == ACT_CLEAR) begin
            step_next = STEP_CLEAR;
          end else begin
            step_next = STEP_FETCH;
          end
        end
      end
      SEQ_WAIT_OUT: step_next = out_free ? uc.target : step;
      default: step_next = STEP_FETCH;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_FETCH;
    end else begin
      step <= step_next;
    end
  end

  // Hold the accepted word
  always_ff @(posedge clk) begin
    if (accept) begin
      left_q  <= left_in;
      right_q <= right_in;
      index_q <= coef_index;
      value_q <= coef_value;
    end
  end

  // Coefficient slot decode: left bank, right bank or dropped
  assign idx9      = {3'd0, index_q};
  assign idx_r9    = idx9 - TAPS_9;
  assign coef_we_l = uc.coef_wr && (idx9 < TAPS_9);
  assign coef_we_r = uc.coef_wr && (idx9 >= TAPS_9) && (idx9 < SLOTS_9);
  assign coef_wa_l = idx9[TW-1:0];
  assign coef_wa_r = idx_r9[TW-1:0];

  // Advance the circular history pointer
  assign wp_next = (wp == LAST_TAP) ? '0 : wp + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp         <= '0;
      hist_vld   <= '0;
      coef_vld_l <= '0;
      coef_vld_r <= '0;
    end else begin
      if (uc.hist_clr) begin
        hist_vld <= '0;
      end else if (uc.hist_wr) begin
        wp           <= wp_next;
        hist_vld[wp_next] <= 1'b1;
      end
      if (coef_we_l) begin
        coef_vld_l[coef_wa_l] <= 1'b1;
      end
      if (coef_we_r) begin
        coef_vld_r[coef_wa_r] <= 1'b1;
      end
    end
  end

  // Walk the taps newest first, one read per cycle
  always_ff @(posedge clk) begin
    if (uc.tap_init) begin
      hist_ra <= wp_next;
      tap_cnt <= '0;
    end else if (uc.tap_rd) begin
      hist_ra <= (hist_ra == '0) ? LAST_TAP : hist_ra - 1'b1;
      tap_cnt <= tap_cnt + 1'b1;
    end
    if (uc.tap_rd) begin
      hist_vld_q   <= hist_vld[hist_ra];
      coef_vld_l_q <= coef_vld_l[tap_cnt];
      coef_vld_r_q <= coef_vld_r[tap_cnt];
    end
  end

  // Track read data and product through the MAC pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v1 <= 1'b0;
      rd_v2 <= 1'b0;
    end else begin
      rd_v1 <= uc.tap_rd;
      rd_v2 <= rd_v1;
    end
  end

  // Result word handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (uc.out_load && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign mctrl.acc_clr  = uc.tap_init;
  assign mctrl.prod_en  = rd_v1;
  assign mctrl.acc_en   = rd_v2;
  assign mctrl.x_fir    = uc.x_fir;
  assign mctrl.x_in     = uc.x_in;
  assign mctrl.scale_en = uc.scale_en;
  assign mctrl.out_load = uc.out_load && out_free;

  // Stores
  sfls_ram #(.WIDTH(SAMPLE_W), .DEPTH(TAPS)) u_hist_l (
    .clk   (clk),
    .we    (uc.hist_wr),
    .waddr (wp_next),
    .wdata (left_q),
    .raddr (hist_ra),
    .rdata (hist_rd_l)
  );

  sfls_ram #(.WIDTH(SAMPLE_W), .DEPTH(TAPS)) u_hist_r (
    .clk   (clk),
    .we    (uc.hist_wr),
    .waddr (wp_next),
    .wdata (right_q),
    .raddr (hist_ra),
    .rdata (hist_rd_r)
  );

  sfls_ram #(.WIDTH(COEF_W), .DEPTH(TAPS)) u_coef_l (
    .clk   (clk),
    .we    (coef_we_l),
    .waddr (coef_wa_l),
    .wdata (value_q),
    .raddr (tap_cnt),
    .rdata (coef_rd_l)
  );

  sfls_ram #(.WIDTH(COEF_W), .DEPTH(TAPS)) u_coef_r (
    .clk   (clk),
    .we    (coef_we_r),
    .waddr (coef_wa_r),
    .wdata (value_q),
    .raddr (tap_cnt),
    .rdata (coef_rd_r)
  );

  // Channel datapaths
  sfls_mac #(.TAPS(TAPS)) u_mac_l (
    .clk       (clk),
    .ctrl      (mctrl),
    .hist_data (hist_rd_l),
    .hist_vld  (hist_vld_q),
    .coef_data (coef_rd_l),
    .coef_vld  (coef_vld_l_q),
    .sample    (left_q),
    .level     (level_left),
    .result    (left_out)
  );

  sfls_mac #(.TAPS(TAPS)) u_mac_r (
    .clk       (clk),
    .ctrl      (mctrl),
    .hist_data (hist_rd_r),
    .hist_vld  (hist_vld_q),
    .coef_data (coef_rd_r),
    .coef_vld  (coef_vld_r_q),
    .sample    (right_q),
    .level     (level_right),
    .result    (right_out)
  );

  // Checks
  a_loop_exit: assert property (@(posedge clk) disable iff (rst)
    (step == STEP_LOOP && tap_last) |=> (step == STEP_DRAIN1))
    else $error("tap loop did not exit after the last tap");

  a_accept_quiet: assert property (@(posedge clk) disable iff (rst)
    accept |-> (!rd_v1 && !rd_v2))
    else $error("word accepted while the MAC pipeline is busy");

  a_coef_bank: assert property (@(posedge clk) disable iff (rst)
    $onehot0({coef_we_l, coef_we_r}))
    else $error("coefficient write hits both banks");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(left_out) && $stable(right_out)))
    else $error("stalled result word was overwritten");

endmodule
`default_nettype wire
